>>> sv/assert_macros.svh
// Assertion macros for the RTL checks.
// No dependencies; included by the files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, skipped while reset is held.
`define SKF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs during reset.
`define SKF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKF_ASSERT(lbl, clk, rst_n, prop, msg)
`define SKF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> sv/skf_pkg.sv
// Shared types and constants of the scalar Kalman filter core.
// No dependencies; used by the datapath, controller, top level and testbench.
package skf_pkg;

  localparam int unsigned NOISE_W = 24;   // Q8.16 variances
  localparam int unsigned GAIN_W  = 17;   // Q1.16 gain, 0..1.0
  localparam int unsigned DIV_W   = 26;   // P + Q + R
  localparam int unsigned SUM_W   = 25;   // P + Q

  localparam logic [NOISE_W-1:0] COV_RESET   = 24'd65536;  // 1.0
  localparam logic [NOISE_W-1:0] RNOISE_RESET = 24'd13107; // 0.2

  localparam logic CFG_IDX_PROCESS_NOISE = 1'b0;
  localparam logic CFG_IDX_MEASURE_NOISE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_UPD
  } skf_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic start;
    logic update;
  } skf_cmd_t;

  typedef struct packed {
    logic div_done;
  } skf_sts_t;

endpackage

>>> sv/skf_meas_if.sv
// Request channel carrying one measurement.
// Depends on nothing; used by the top level.
interface skf_meas_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measurement;
  modport source (output valid, output measurement, input ready);
  modport sink (input valid, input measurement, output ready);
endinterface

>>> sv/skf_est_if.sv
// Result channel carrying one filtered estimate.
// Depends on nothing; used by the top level.
interface skf_est_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] estimate;
  modport source (output valid, output estimate, input ready);
  modport sink (input valid, input estimate, output ready);
endinterface

>>> sv/skf_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Standalone; instantiated by skf_datapath.
module skf_div #(
  parameter int unsigned DW = 26,
  parameter int unsigned QW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] rem_i,   // upper numerator bits, must be below div_i
  input  logic [QW-1:0] lo_i,    // lower numerator bits, shifted in MSB first
  input  logic [DW-1:0] div_i,
  output logic          busy,
  output logic [QW-1:0] quo_o
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] lo_r, lo_nxt;
  logic [DW-1:0] div_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_r, lo_r[QW-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    rem_nxt = rem_r;
    lo_nxt  = lo_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = rem_i;
      lo_nxt  = lo_i;
      cnt_nxt = CW'(QW);
    end else if (cnt_r != '0) begin
      // remainder stays below the divisor, so it fits DW bits
      rem_nxt = ge ? DW'(trial - {1'b0, div_r}) : DW'(trial);
      lo_nxt  = {lo_r[QW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    if (start) begin
      div_r <= div_i;
    end
  end

  assign busy  = cnt_r != '0;
  assign quo_o = lo_r;

endmodule

>>> sv/skf_datapath.sv
// Datapath: noise registers, filter state, multipliers and two dividers.
// Depends on skf_pkg and skf_div; driven by skf_ctrl.
module skf_datapath
  import skf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [NOISE_W-1:0]   cfg_data,
  input  logic signed [31:0]   measurement,
  input  skf_cmd_t             cmd,
  output skf_sts_t             sts,
  output logic signed [31:0]   estimate
);

  logic [NOISE_W-1:0] q_r, r_r, p_r;
  logic [GAIN_W-1:0]  k_r;
  logic signed [31:0] x_r;
  logic signed [32:0] diff_r;
  logic [SUM_W-1:0]   s_r;
  logic [DIV_W-1:0]   d_r;
  logic signed [50:0] prod_r, prod_nxt, rnd;
  logic [48:0]        numc_r, numc_nxt;
  logic signed [34:0] corr_r;
  logic signed [35:0] est_sum;
  logic signed [31:0] est_sat;
  logic signed [31:0] est_r;
  logic signed [17:0] k_s;
  logic               busy_g, busy_c;
  logic [GAIN_W-1:0]  quo_g;
  logic [NOISE_W-1:0] quo_c;

  // noise registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
      r_r <= RNOISE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_PROCESS_NOISE: q_r <= cfg_data;
        CFG_IDX_MEASURE_NOISE: r_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign k_s      = {1'b0, k_r};
  assign prod_nxt = diff_r * k_s;
  assign numc_nxt = r_r * s_r;
  // |prod| < 2**49, so the rounding add cannot overflow
  assign rnd      = prod_r + 51'sd32768;
  assign est_sum  = {{4{x_r[31]}}, x_r} + {corr_r[34], corr_r};

  always_comb begin
    if (est_sum[35:31] == 5'b00000 || est_sum[35:31] == 5'b11111) begin
      est_sat = est_sum[31:0];
    end else if (est_sum[35]) begin
      est_sat = 32'sh8000_0000;
    end else begin
      est_sat = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      p_r <= COV_RESET;
      k_r <= '0;
    end else if (cmd.update) begin
      x_r <= est_sat;
      if (d_r == '0) begin
        k_r <= '0;
        p_r <= '0;
      end else begin
        k_r <= quo_g;
        p_r <= quo_c;
      end
    end
    if (cmd.load) begin
      diff_r <= {measurement[31], measurement} - {x_r[31], x_r};
      s_r    <= SUM_W'(p_r) + SUM_W'(q_r);
      d_r    <= DIV_W'(p_r) + DIV_W'(q_r) + DIV_W'(r_r);
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
      numc_r <= numc_nxt;
    end
    if (cmd.start) begin
      corr_r <= rnd[50:16];
    end
    if (cmd.update) begin
      est_r <= est_sat;
    end
  end

  // gain: (S << 16) / D, quotient at most 1.0
  skf_div #(.DW(DIV_W), .QW(GAIN_W)) u_div_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .rem_i (DIV_W'(s_r[SUM_W-1:1])),
    .lo_i  ({s_r[0], 16'd0}),
    .div_i (d_r),
    .busy  (busy_g),
    .quo_o (quo_g)
  );

  // covariance: R * S / D, quotient never exceeds R
  skf_div #(.DW(DIV_W), .QW(NOISE_W)) u_div_cov (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .rem_i (DIV_W'(numc_r[48:24])),
    .lo_i  (numc_r[23:0]),
    .div_i (d_r),
    .busy  (busy_c),
    .quo_o (quo_c)
  );

  assign sts.div_done = !busy_g && !busy_c;
  assign estimate     = est_r;

endmodule

>>> sv/skf_ctrl.sv
// Controller state machine sequencing one request through the datapath.
// Depends on skf_pkg and assert_macros.svh; drives skf_datapath.
`include "assert_macros.svh"
module skf_ctrl
  import skf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  skf_sts_t sts,
  output skf_cmd_t cmd
);

  skf_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (sts.div_done) state_nxt = ST_UPD;
      ST_UPD:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL:   cmd.mul = 1'b1;
      ST_START: cmd.start = 1'b1;
      ST_DIV:   ;
      ST_UPD:   cmd.update = out_free;
      default:  ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `SKF_ASSERT(a_out_from_update, clk, rst_n, $rose(out_valid_r) |-> $past(cmd.update), "result raised without an update")
  `SKF_ASSERT(a_update_after_div, clk, rst_n, cmd.update |-> sts.div_done, "update while dividers busy")
  `SKF_ASSERT(a_start_runs_div, clk, rst_n, cmd.start |=> !sts.div_done, "dividers did not start")
  `SKF_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "reset did not clear control")

endmodule

>>> sv/scalar_kalman_filter_core.sv
// Top level of the scalar Kalman filter core.
// Depends on skf_pkg, skf_meas_if, skf_est_if, skf_ctrl and skf_datapath.
//
//   channel   dir  handshake          payload
//   in_chan   in   valid/ready        measurement  s32 Q16.16
//   out_chan  out  valid/ready        estimate     s32 Q16.16
//   cfg_*     in   cfg_we             cfg_index 1b, cfg_data 24b Q8.16
//
// An accepted request steps through ST_MUL, ST_START, ST_DIV and ST_UPD before
// its estimate reaches the result register, and no new request is accepted
// until then. The 24-step covariance divide is the longest part; the gain
// divide runs alongside it in 17 steps. Requests are processed one at a time.
// A finished estimate waits in the output register; the next request is
// accepted while it is held. Reset is synchronous and returns state, gain,
// covariance and the noise registers to their reset values; a stalled output
// holds the core.
module scalar_kalman_filter_core
  import skf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  skf_meas_if.sink           in_chan,
  skf_est_if.source          out_chan,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [NOISE_W-1:0] cfg_data
);

  skf_cmd_t cmd;
  skf_sts_t sts;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  skf_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .measurement (in_chan.measurement),
    .cmd         (cmd),
    .sts         (sts),
    .estimate    (out_chan.estimate)
  );

endmodule

>>> sim/tb.sv
// Testbench for scalar_kalman_filter_core: a built-in filter predictor checks every estimate.
// Needs skf_pkg, skf_meas_if, skf_est_if and the core RTL; reads and writes no files.
`timescale 1ns / 1ps

module tb;
  import skf_pkg::*;

  localparam longint EST_MAX = 2147483647;
  localparam longint EST_MIN = -EST_MAX - 1;
  localparam int PHASE_SAMPLES = 244;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_IDX_PROCESS_NOISE;
  logic [NOISE_W-1:0] cfg_data = '0;

  skf_meas_if meas_chan();
  skf_est_if est_chan();

  scalar_kalman_filter_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(meas_chan),
    .out_chan(est_chan),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // filter state as the predictor tracks it
  logic signed [31:0] x_est = '0;
  logic [NOISE_W-1:0] cov = COV_RESET;
  logic [GAIN_W-1:0] gain = '0;
  logic [NOISE_W-1:0] q_noise = '0;
  logic [NOISE_W-1:0] r_noise = RNOISE_RESET;

  logic signed [31:0] sample_q[$];
  logic signed [31:0] estimate_q[$];
  int samples_queued = 0;
  int samples_taken = 0;
  int bad_results = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Estimate uses the previous gain; gain and covariance are refreshed afterwards.
  function automatic logic signed [31:0] filter_step(input logic signed [31:0] meas);
    longint diff;
    longint prod;
    longint est;
    longint unsigned s;
    longint unsigned d;
    diff = longint'(meas) - longint'(x_est);
    prod = diff * longint'(gain);
    est = longint'(x_est) + ((prod + 32768) >>> 16);
    if (est > EST_MAX) est = EST_MAX;
    if (est < EST_MIN) est = EST_MIN;
    s = longint'(cov) + longint'(q_noise);
    d = s + longint'(r_noise);
    if (d == 0) begin
      gain = '0;
      cov = '0;
    end else begin
      gain = GAIN_W'((s << 16) / d);
      cov = NOISE_W'((longint'(r_noise) * s) / d);
    end
    x_est = est[31:0];
    return est[31:0];
  endfunction

  task automatic note_mismatch(input string what, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    bad_results++;
    if (bad_results <= 10)
      $display("%0t: %s: expected estimate %0d (%h), got %0d (%h)",
               $time, what, want, want, got, got);
  endtask

  // request side
  always @(posedge clk) begin
    if (!rst_n) begin
      meas_chan.valid <= 1'b0;
    end else begin
      if (meas_chan.valid && meas_chan.ready) begin
        estimate_q.push_back(filter_step(meas_chan.measurement));
        samples_taken++;
      end
      if (!meas_chan.valid || meas_chan.ready) begin
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          meas_chan.valid <= 1'b1;
          meas_chan.measurement <= sample_q.pop_front();
        end else begin
          meas_chan.valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    logic signed [31:0] want;
    if (!rst_n) begin
      est_chan.ready <= 1'b0;
    end else begin
      if (est_chan.valid && est_chan.ready) begin
        if (estimate_q.size() == 0) begin
          note_mismatch("estimate with no request pending", 'x, est_chan.estimate);
        end else begin
          want = estimate_q.pop_front();
          if (est_chan.estimate !== want)
            note_mismatch("estimate mismatch", want, est_chan.estimate);
        end
      end
      est_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic enqueue(input logic signed [31:0] s);
    sample_q.push_back(s);
    samples_queued++;
  endtask

  task automatic drain();
    while (samples_taken != samples_queued || estimate_q.size() != 0)
      @(posedge clk);
  endtask

  // both registers, written one after the other while the core is idle
  task automatic set_noise(input logic [NOISE_W-1:0] q, input logic [NOISE_W-1:0] r);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_PROCESS_NOISE;
    cfg_data <= q;
    @(posedge clk);
    cfg_index <= CFG_IDX_MEASURE_NOISE;
    cfg_data <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    q_noise = q;
    r_noise = r;
  endtask

  initial begin
    logic signed [31:0] opening [14];
    logic [NOISE_W-1:0] q;
    logic [NOISE_W-1:0] r;
    int center;
    int pick;
    int ph;
    opening = '{32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                32'sh8000_0000, -32'sd1, 32'sd1, 32'sh0001_0000, 32'shFFFF_0000,
                32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0000, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF};
    meas_chan.valid = 1'b0;
    meas_chan.measurement = '0;
    est_chan.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset noise values, full-scale swings first (gain is zero on the first request)
    foreach (opening[i]) enqueue(opening[i]);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    for (ph = 1; ph <= 8; ph++) begin
      case (ph)
        1: begin q = '0; r = '0; end    // divisor goes to zero after one request
        2: begin q = '1; r = '0; end    // unity gain
        3: begin q = '0; r = '1; end
        4: begin q = '1; r = '1; end
        5: begin
          q = NOISE_W'($urandom_range(0, 65536));
          r = NOISE_W'($urandom_range(0, 65536));
        end
        default: begin
          q = NOISE_W'($urandom_range(0, 24'hFF_FFFF));
          r = NOISE_W'($urandom_range(0, 24'hFF_FFFF));
        end
      endcase
      set_noise(q, r);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 66; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 66; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase

      // mostly a noisy level that drifts and jumps, some raw words and rail values
      center = int'($urandom);
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)
          center = int'($urandom);
        else if (pick < 10)
          center = center + int'($urandom_range(0, 131071)) - 65536;
        if (pick < 70)
          enqueue(center + int'($urandom_range(0, 8191)) - 4096);
        else if (pick < 90)
          enqueue($urandom);
        else
          case (pick % 4)
            0: enqueue(32'sh7FFF_FFFF);
            1: enqueue(32'sh8000_0000);
            2: enqueue(32'sh0000_0000);
            default: enqueue(-32'sd1);
          endcase
      end
      drain();
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (bad_results == 0 && estimate_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/skf_pkg.sv
sv/skf_meas_if.sv
sv/skf_est_if.sv
sv/skf_div.sv
sv/skf_datapath.sv
sv/skf_ctrl.sv
sv/scalar_kalman_filter_core.sv
sim/tb.sv
